@@ hw/rtl/rope_pkg.sv @@
// Shared constants, types and the arctangent table of the rotary embedding block.
// No dependencies.
`timescale 1ns / 1ps

package rope_pkg;

	localparam int MAX_PAIRS = 64;
	localparam int IDX_W = $clog2(MAX_PAIRS);
	localparam int POS_BITS = 16;
	localparam int CORDIC_STAGES = 24;

	localparam int ANGLE_W = POS_BITS + 32;
	localparam int RED_STEPS = ANGLE_W - 34;
	localparam int Z_W = 35;
	localparam int XY_W = 34;

	localparam logic [34:0] TWO_PI_Q32 = 35'h6487ED511;
	localparam logic signed [Z_W-1:0] PI_Q30 = 35'sh0C90FDAA2;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sh06487ED51;
	localparam logic signed [Z_W-1:0] TWO_PI_Q30 = 35'sh1921FB544;
	localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 34'sh026DD3B6A;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_ROTATE = 1'b1
	} action_t;

	typedef struct packed {
		logic signed [31:0] xe;
		logic signed [31:0] xo;
	} pair_t;

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h3243F6A8;
			1: r = 32'h1DAC6705;
			2: r = 32'h0FADBAFC;
			3: r = 32'h07F56EA6;
			4: r = 32'h03FEAB76;
			5: r = 32'h01FFD55B;
			6: r = 32'h00FFFAAA;
			7: r = 32'h007FFF55;
			8: r = 32'h003FFFEA;
			9: r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			24: r = 32'h0000003F;
			25: r = 32'h0000001F;
			26: r = 32'h0000000F;
			27: r = 32'h00000008;
			28: r = 32'h00000004;
			29: r = 32'h00000002;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/rope_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
`timescale 1ns / 1ps

interface rope_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [5:0] pair_index;
	logic [31:0] freq_value;
	logic [15:0] position;
	logic signed [31:0] x_even;
	logic signed [31:0] x_odd;

	modport source (output valid, action, pair_index, freq_value, position, x_even, x_odd,
		input ready);
	modport sink (input valid, action, pair_index, freq_value, position, x_even, x_odd,
		output ready);
endinterface

interface rope_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] y_even;
	logic signed [31:0] y_odd;

	modport source (output valid, y_even, y_odd, input ready);
	modport sink (input valid, y_even, y_odd, output ready);
endinterface

@@ hw/rtl/rope_mem.sv @@
// Inverse-frequency table memory with one write port and one registered read port.
// Depends on rope_pkg.
`timescale 1ns / 1ps

module rope_mem (
	input  logic clk,
	input  logic adv,
	input  logic wr_en,
	input  logic [rope_pkg::IDX_W-1:0] wr_addr,
	input  logic [31:0] wr_data,
	input  logic [rope_pkg::IDX_W-1:0] rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem [rope_pkg::MAX_PAIRS];
	logic [31:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (adv) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

@@ hw/rtl/rope_angle.sv @@
// Angle pipeline: position times table entry, reduction modulo two pi, quadrant fold.
// Depends on rope_pkg.
`timescale 1ns / 1ps

module rope_angle (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_i,
	input  logic [rope_pkg::POS_BITS-1:0] pos_i,
	input  logic [31:0] freq_i,
	input  rope_pkg::pair_t pair_i,
	output logic valid_o,
	output logic signed [rope_pkg::Z_W-1:0] z_o,
	output logic flip_o,
	output rope_pkg::pair_t pair_o
);

	localparam int N = rope_pkg::RED_STEPS;

	logic [rope_pkg::ANGLE_W-1:0] red_s [N+1];
	logic red_v_s [N+1];
	rope_pkg::pair_t red_p_s [N+1];

	logic signed [rope_pkg::Z_W-1:0] z_s1;
	logic f1_v_s1;
	rope_pkg::pair_t f1_p_s1;
	logic signed [rope_pkg::Z_W-1:0] z_s2;
	logic f2_v_s2;
	logic flip_s2;
	rope_pkg::pair_t f2_p_s2;

	logic signed [rope_pkg::Z_W-1:0] z_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_v_s[0] <= 1'b0;
		end else if (adv) begin
			red_v_s[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s[0] <= rope_pkg::ANGLE_W'(pos_i) * rope_pkg::ANGLE_W'(freq_i);
			red_p_s[0] <= pair_i;
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_red
		localparam logic [rope_pkg::ANGLE_W-1:0] SH =
			rope_pkg::ANGLE_W'(rope_pkg::TWO_PI_Q32) << (N - 1 - g);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				red_v_s[g+1] <= 1'b0;
			end else if (adv) begin
				red_v_s[g+1] <= red_v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				red_s[g+1] <= (red_s[g] >= SH) ? red_s[g] - SH : red_s[g];
				red_p_s[g+1] <= red_p_s[g];
			end
		end
	end

	assign z_in = $signed({2'b00, red_s[N][34:2]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_v_s1 <= 1'b0;
			f2_v_s2 <= 1'b0;
		end else if (adv) begin
			f1_v_s1 <= red_v_s[N];
			f2_v_s2 <= f1_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s1 <= (z_in >= rope_pkg::PI_Q30) ? z_in - rope_pkg::TWO_PI_Q30 : z_in;
			f1_p_s1 <= red_p_s[N];
			if (z_s1 > rope_pkg::HALF_PI_Q30) begin
				z_s2 <= z_s1 - rope_pkg::PI_Q30;
				flip_s2 <= 1'b1;
			end else if (z_s1 < -rope_pkg::HALF_PI_Q30) begin
				z_s2 <= z_s1 + rope_pkg::PI_Q30;
				flip_s2 <= 1'b1;
			end else begin
				z_s2 <= z_s1;
				flip_s2 <= 1'b0;
			end
			f2_p_s2 <= f1_p_s1;
		end
	end

	assign valid_o = f2_v_s2;
	assign z_o = z_s2;
	assign flip_o = flip_s2;
	assign pair_o = f2_p_s2;

endmodule

@@ hw/rtl/rope_cordic.sv @@
// Pipelined rotation-mode CORDIC, one stage per iteration, giving cosine and sine.
// Depends on rope_pkg.
`timescale 1ns / 1ps

module rope_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_i,
	input  logic signed [rope_pkg::Z_W-1:0] z_i,
	input  logic flip_i,
	input  rope_pkg::pair_t pair_i,
	output logic valid_o,
	output logic signed [rope_pkg::XY_W-1:0] cos_o,
	output logic signed [rope_pkg::XY_W-1:0] sin_o,
	output logic flip_o,
	output rope_pkg::pair_t pair_o
);

	localparam int N = rope_pkg::CORDIC_STAGES;

	logic signed [rope_pkg::XY_W-1:0] x_s [N+1];
	logic signed [rope_pkg::XY_W-1:0] y_s [N+1];
	logic signed [rope_pkg::Z_W-1:0] z_s [N+1];
	logic v_s [N+1];
	logic f_s [N+1];
	rope_pkg::pair_t p_s [N+1];

	assign x_s[0] = rope_pkg::INV_GAIN_Q30;
	assign y_s[0] = '0;
	assign z_s[0] = z_i;
	assign v_s[0] = valid_i;
	assign f_s[0] = flip_i;
	assign p_s[0] = pair_i;

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam logic signed [rope_pkg::Z_W-1:0] ATAN =
			$signed({3'b000, rope_pkg::atan_q30(g)});

		logic signed [rope_pkg::XY_W-1:0] dx;
		logic signed [rope_pkg::XY_W-1:0] dy;

		assign dx = y_s[g] >>> g;
		assign dy = x_s[g] >>> g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (z_s[g] >= 0) begin
					x_s[g+1] <= x_s[g] - dx;
					y_s[g+1] <= y_s[g] + dy;
					z_s[g+1] <= z_s[g] - ATAN;
				end else begin
					x_s[g+1] <= x_s[g] + dx;
					y_s[g+1] <= y_s[g] - dy;
					z_s[g+1] <= z_s[g] + ATAN;
				end
				f_s[g+1] <= f_s[g];
				p_s[g+1] <= p_s[g];
			end
		end
	end

	assign valid_o = v_s[N];
	assign cos_o = x_s[N];
	assign sin_o = y_s[N];
	assign flip_o = f_s[N];
	assign pair_o = p_s[N];

endmodule

@@ hw/rtl/rope_out.sv @@
// Output arithmetic: four products, signed sums, rounding, saturation and result register.
// Depends on rope_pkg.
`timescale 1ns / 1ps

module rope_out (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_i,
	input  logic signed [rope_pkg::XY_W-1:0] cos_i,
	input  logic signed [rope_pkg::XY_W-1:0] sin_i,
	input  logic flip_i,
	input  rope_pkg::pair_t pair_i,
	output logic valid_o,
	output logic signed [31:0] y_even_o,
	output logic signed [31:0] y_odd_o
);

	logic signed [31:0] c32;
	logic signed [31:0] s32;

	logic signed [63:0] p1_s1, p2_s1, p3_s1, p4_s1;
	logic v_s1, f_s1;
	logic signed [64:0] se_s2, so_s2;
	logic v_s2;
	logic valid_q;
	logic signed [31:0] ye_q, yo_q;

	logic signed [64:0] de, dodd;

	assign c32 = cos_i[31:0];
	assign s32 = sin_i[31:0];

	function automatic logic signed [31:0] sat_round(input logic signed [64:0] acc);
		logic signed [65:0] a;
		logic signed [65:0] v;
		logic signed [31:0] r;
		a = 66'(acc) + 66'sd536870912;
		v = a >>> 30;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign de = 65'(p1_s1) - 65'(p2_s1);
	assign dodd = 65'(p3_s1) + 65'(p4_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid_i;
			v_s2 <= v_s1;
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s1 <= pair_i.xe * c32;
			p2_s1 <= pair_i.xo * s32;
			p3_s1 <= pair_i.xe * s32;
			p4_s1 <= pair_i.xo * c32;
			f_s1 <= flip_i;
			se_s2 <= f_s1 ? -de : de;
			so_s2 <= f_s1 ? -dodd : dodd;
			ye_q <= sat_round(se_s2);
			yo_q <= sat_round(so_s2);
		end
	end

	assign valid_o = valid_q;
	assign y_even_o = ye_q;
	assign y_odd_o = yo_q;

endmodule

@@ hw/rtl/table_rotary_position_embedding.sv @@
// Each accepted rotate beat gives one result beat; loads give no beat.
// Throughput: one beat per cycle; the whole pipeline advances together and stalls only
// while the result register holds a beat that is not taken.
// Reset clears all valid bits; the frequency table is undefined until written.
// Depends on rope_pkg, rope_if, rope_mem, rope_angle, rope_cordic and rope_out.
`timescale 1ns / 1ps

module table_rotary_position_embedding (
	input  logic clk,
	input  logic arst_n,
	rope_in_if.sink item,
	rope_out_if.source result
);

	logic adv;
	logic accept;
	logic is_rot;
	logic [rope_pkg::IDX_W-1:0] idx;
	logic [31:0] freq;

	logic v_s1;
	logic [rope_pkg::POS_BITS-1:0] pos_s1;
	rope_pkg::pair_t pair_s1;
	rope_pkg::pair_t pair_in;

	logic a_valid, a_flip;
	logic signed [rope_pkg::Z_W-1:0] a_z;
	rope_pkg::pair_t a_pair;

	logic c_valid, c_flip;
	logic signed [rope_pkg::XY_W-1:0] c_cos, c_sin;
	rope_pkg::pair_t c_pair;

	assign adv = !result.valid || result.ready;
	assign item.ready = adv;
	assign accept = item.valid && adv;
	assign is_rot = (item.action == rope_pkg::ACT_ROTATE);
	assign idx = item.pair_index[rope_pkg::IDX_W-1:0];
	assign pair_in.xe = item.x_even;
	assign pair_in.xo = item.x_odd;

	rope_mem u_mem (
		.clk(clk),
		.adv(adv),
		.wr_en(accept && !is_rot),
		.wr_addr(idx),
		.wr_data(item.freq_value),
		.rd_addr(idx),
		.rd_data(freq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept && is_rot;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= item.position[rope_pkg::POS_BITS-1:0];
			pair_s1 <= pair_in;
		end
	end

	rope_angle u_angle (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_i(v_s1),
		.pos_i(pos_s1),
		.freq_i(freq),
		.pair_i(pair_s1),
		.valid_o(a_valid),
		.z_o(a_z),
		.flip_o(a_flip),
		.pair_o(a_pair)
	);

	rope_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_i(a_valid),
		.z_i(a_z),
		.flip_i(a_flip),
		.pair_i(a_pair),
		.valid_o(c_valid),
		.cos_o(c_cos),
		.sin_o(c_sin),
		.flip_o(c_flip),
		.pair_o(c_pair)
	);

	rope_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_i(c_valid),
		.cos_i(c_cos),
		.sin_i(c_sin),
		.flip_i(c_flip),
		.pair_i(c_pair),
		.valid_o(result.valid),
		.y_even_o(result.y_even),
		.y_odd_o(result.y_odd)
	);

endmodule
